// ===== rtl/grain_area_histogram_assert.svh =====
// Assertion macros for the grain area histogram block.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef GRAIN_AREA_HISTOGRAM_ASSERT_SVH
`define GRAIN_AREA_HISTOGRAM_ASSERT_SVH

// Same-cycle implication, held off during reset
`define GAH_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset
`define GAH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gah_pkg.sv =====
// Shared types and constants for the grain area histogram block.
// No dependencies.
package gah_pkg;

    localparam int AREA_W            = 32;
    localparam int GID_W             = 10;
    localparam int GCNT_W            = 11;
    localparam int GT_W              = 11;
    localparam logic [GT_W-1:0] GT_MAX = '1;
    localparam int DEF_MAX_GRAINS    = 1024;
    localparam int DEF_MAX_BIN_ATOMS = 64;
    localparam int DEF_HIST_BINS     = 25;
    localparam int QUEUE_DEPTH       = 2;
    localparam int QCW               = $clog2(QUEUE_DEPTH + 1);
    localparam int PADDR_W           = 4;

    // Request opcodes
    typedef enum logic {
        OP_ATOM,
        OP_FINISH
    } t_op;

    // Register indexes on the APB port
    typedef enum logic [1:0] {
        REG_BIN_AREA,
        REG_GRAIN_COUNT,
        REG_BOX_AREA
    } t_reg;

    // Back-end sequencer states
    typedef enum logic [3:0] {
        BS_CLEAR, BS_IDLE, BS_SHARE, BS_MRD, BS_MWAIT, BS_AUPD,
        BS_SRD, BS_SCMP, BS_RANGE, BS_HRD, BS_HMUL, BS_HDS, BS_HDIV,
        BS_CMUL, BS_CDS, BS_CDIV
    } t_bs;

    // Back-end status towards the top level
    typedef struct packed {
        logic clearing;
        logic active;
    } t_back_stat;

endpackage

// ===== rtl/gah_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on gah_pkg for default sizes.
module gah_ram #(
    parameter int W = gah_pkg::AREA_W,
    parameter int D = gah_pkg::DEF_MAX_GRAINS
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/gah_cmd_queue.sv =====
// Two-entry request queue between the front end and the back end.
// Depends on gah_pkg for the queue depth.
module gah_cmd_queue #(
    parameter int W = 9
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic [W-1:0]           i_din,
    input  logic                   i_pop,
    output logic [W-1:0]           o_dout,
    output logic [gah_pkg::QCW-1:0] o_count
);
    import gah_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [W-1:0]   r_buf [QUEUE_DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [QCW-1:0] r_count;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            r_count <= r_count + QCW'(i_push) - QCW'(i_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_din;
        end
    end

    assign o_dout  = r_buf[r_rp];
    assign o_count = r_count;
endmodule

// ===== rtl/gah_front.sv =====
// Front end: takes requests, buffers the atoms of the open bin in the member RAM
// (two banks) and queues close and finish requests. Depends on gah_pkg.
module gah_front #(
    parameter int MAX_BIN_ATOMS = gah_pkg::DEF_MAX_BIN_ATOMS,
    parameter int MAW  = (MAX_BIN_ATOMS > 1) ? $clog2(MAX_BIN_ATOMS) : 1,
    parameter int CNTW = $clog2(MAX_BIN_ATOMS + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic                     i_opcode,
    input  logic [gah_pkg::GID_W-1:0] i_grain_id,
    input  logic                     i_last_in_bin,
    output logic                     o_mem_we,
    output logic [MAW:0]             o_mem_waddr,
    output logic [gah_pkg::GID_W-1:0] o_mem_wdata,
    output logic                     o_push,
    output logic [CNTW+1:0]          o_cmd
);
    import gah_pkg::*;

    typedef struct packed {
        t_op             op;
        logic            bank;
        logic [CNTW-1:0] count;
    } t_cmd;

    logic            r_bank;
    logic [CNTW-1:0] r_cnt;
    logic            full;
    logic            is_atom;
    t_cmd            cmd;

    assign is_atom = (t_op'(i_opcode) == OP_ATOM);
    assign full    = (r_cnt == CNTW'(MAX_BIN_ATOMS));

    // member buffer write, atoms beyond a full buffer are dropped
    assign o_mem_we    = i_accept && is_atom && !full;
    assign o_mem_waddr = {r_bank, r_cnt[MAW-1:0]};
    assign o_mem_wdata = i_grain_id;

    // close on the last atom of a bin, finish on opcode
    always_comb begin
        cmd.op    = is_atom ? OP_ATOM : OP_FINISH;
        cmd.bank  = r_bank;
        cmd.count = full ? r_cnt : r_cnt + CNTW'(1);
    end
    assign o_push = i_accept && (!is_atom || i_last_in_bin);
    assign o_cmd  = cmd;

    // bank and fill count of the open bin
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank <= 1'b0;
            r_cnt  <= '0;
        end else if (i_accept) begin
            if (!is_atom) begin
                r_cnt <= '0;
            end else if (i_last_in_bin) begin
                r_cnt  <= '0;
                r_bank <= ~r_bank;
            end else if (!full) begin
                r_cnt <= r_cnt + CNTW'(1);
            end
        end
    end
endmodule

// ===== rtl/gah_div.sv =====
// Shared restoring divider, one quotient bit per cycle, up to 32 steps.
// The caller supplies the upper remainder and the left-aligned low bits.
module gah_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_rem_init,
    input  logic [31:0] i_bits,
    input  logic [5:0]  i_steps,
    input  logic [31:0] i_den,
    output logic        o_busy,
    output logic        o_done,
    output logic [31:0] o_quot
);
    logic        r_busy;
    logic        r_done;
    logic [31:0] r_rem;
    logic [31:0] r_bits;
    logic [31:0] r_den;
    logic [31:0] r_q;
    logic [5:0]  r_cnt;
    logic [32:0] rem2;
    logic [32:0] diff;
    logic        ge;

    // one trial subtraction
    assign rem2 = {r_rem, r_bits[31]};
    assign ge   = (rem2 >= {1'b0, r_den});
    assign diff = rem2 - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 6'd1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_rem_init;
            r_bits <= i_bits;
            r_den  <= i_den;
            r_q    <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[31:0] : rem2[31:0];
            r_bits <= {r_bits[30:0], 1'b0};
            r_q    <= {r_q[30:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// ===== rtl/gah_back.sv =====
// Back end: clears the area store, closes bins into it and runs the finish
// scans and histogram output. Depends on gah_pkg, gah_ram, gah_div and the assertion macros header.
`include "grain_area_histogram_assert.svh"
module gah_back #(
    parameter int MAX_GRAINS    = gah_pkg::DEF_MAX_GRAINS,
    parameter int MAX_BIN_ATOMS = gah_pkg::DEF_MAX_BIN_ATOMS,
    parameter int HIST_BINS     = gah_pkg::DEF_HIST_BINS,
    parameter int MAW  = (MAX_BIN_ATOMS > 1) ? $clog2(MAX_BIN_ATOMS) : 1,
    parameter int CNTW = $clog2(MAX_BIN_ATOMS + 1),
    parameter int HBW  = $clog2(HIST_BINS)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [gah_pkg::AREA_W-1:0] i_bin_area,
    input  logic [gah_pkg::GCNT_W-1:0] i_grain_count,
    input  logic [gah_pkg::AREA_W-1:0] i_box_area,
    input  logic [CNTW+1:0]            i_q_cmd,
    input  logic [gah_pkg::QCW-1:0]    i_q_count,
    output logic                       o_q_pop,
    output logic [MAW:0]               o_mem_raddr,
    input  logic [gah_pkg::GID_W-1:0]  i_mem_rdata,
    output gah_pkg::t_back_stat        o_stat,
    output logic                       o_valid,
    output logic [HBW-1:0]             o_bin_index,
    output logic [gah_pkg::AREA_W-1:0] o_bin_centre,
    output logic [gah_pkg::GT_W-1:0]   o_grain_total,
    output logic                       o_last_bin
);
    import gah_pkg::*;

    localparam int GW  = $clog2(MAX_GRAINS);
    localparam int GCW = $clog2(MAX_GRAINS + 1);
    localparam int MW  = HBW + 1;
    localparam int PW  = AREA_W + MW;
    // reciprocal of HIST_BINS for floor(range / (2*HIST_BINS)) on range/2
    localparam int     CQS = 31 + HBW;
    localparam longint CQM = ((longint'(1) << CQS) + longint'(HIST_BINS) - 1)
                             / longint'(HIST_BINS);
    // reciprocal of 2*HIST_BINS for the small fractional part
    localparam int     CFS = 3 * MW;
    localparam longint CFM = ((longint'(1) << CFS) + longint'(2 * HIST_BINS) - 1)
                             / longint'(2 * HIST_BINS);
    localparam int     CFW = 4 * MW + 2;

    typedef struct packed {
        t_op             op;
        logic            bank;
        logic [CNTW-1:0] count;
    } t_cmd;

    t_bs              r_state, n_state;
    t_cmd             cmd;
    logic [GCW-1:0]   r_i;
    logic [GCW-1:0]   r_n;
    logic [GCW-1:0]   n_c;
    logic [HBW-1:0]   r_j;
    logic             r_bank;
    logic [CNTW-1:0]  r_cnt;
    logic [CNTW-1:0]  r_k;
    logic [GW-1:0]    r_g;
    logic [31:0]      r_share;
    logic [31:0]      r_min;
    logic [31:0]      r_max;
    logic [31:0]      r_range;
    logic [PW-1:0]    r_prod;
    logic [31:0]      r_cq;
    logic [31:0]      r_cp;
    logic [2*MW-1:0]  r_cv;
    logic [GT_W-1:0]  r_hist [HIST_BINS];
    logic             r_valid;
    logic [HBW-1:0]   r_bin_index;
    logic [31:0]      r_centre;
    logic [GT_W-1:0]  r_total;
    logic             r_last;

    logic             area_we;
    logic [GW-1:0]    area_waddr;
    logic [31:0]      area_wdata;
    logic [GW-1:0]    area_raddr;
    logic [31:0]      area_rdata;
    logic             div_start;
    logic [31:0]      div_rem;
    logic [31:0]      div_bits;
    logic [5:0]       div_steps;
    logic [31:0]      div_den;
    logic             div_busy;
    logic             div_done;
    logic [31:0]      div_quot;
    logic             pop;
    logic [31:0]      g32;
    logic             g_ok;
    logic             last_member;
    logic             last_grain;
    logic             hit;
    logic [32:0]      upd_sum;
    logic [32:0]      ctr_sum;
    logic [31:0]      n32;
    logic [HBW-1:0]   q_idx;
    logic             hist_inc;
    logic [HBW-1:0]   hist_sel;
    logic [31:0]      cq_m;
    logic [63:0]      cq_prod;
    logic [MW-1:0]    c_odd;
    logic [31:0]      c_rem;
    logic [2*MW-1:0]  c_var;
    logic [CFW-1:0]   cf_prod;
    logic [MW-1:0]    c_fine;

    assign cmd = i_q_cmd;

    gah_ram #(.W(AREA_W), .D(MAX_GRAINS)) u_area (
        .i_clk  (i_clk),
        .i_we   (area_we),
        .i_waddr(area_waddr),
        .i_wdata(area_wdata),
        .i_raddr(area_raddr),
        .o_rdata(area_rdata)
    );

    gah_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_rem_init(div_rem),
        .i_bits    (div_bits),
        .i_steps   (div_steps),
        .i_den     (div_den),
        .o_busy    (div_busy),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    // helpers
    assign pop         = (r_state == BS_IDLE) && (i_q_count != '0);
    assign g32         = 32'(i_mem_rdata);
    assign g_ok        = (g32 < 32'(MAX_GRAINS));
    assign last_member = (r_k == r_cnt - CNTW'(1));
    assign last_grain  = (r_i == r_n - GCW'(1));
    assign hit         = (r_range != '0) && (area_rdata >= r_min);
    assign upd_sum     = {1'b0, area_rdata} + {1'b0, r_share};
    assign n32         = (32'(i_grain_count) > 32'(MAX_GRAINS)) ? 32'(MAX_GRAINS)
                                                                 : 32'(i_grain_count);
    assign n_c         = n32[GCW-1:0];
    assign q_idx       = (div_quot > 32'(HIST_BINS - 1)) ? HBW'(HIST_BINS - 1)
                                                         : div_quot[HBW-1:0];

    // bin centre: range = 2H*q + r, so (2j+1)*range/2H = (2j+1)*q + (2j+1)*r/2H
    assign cq_m    = 32'(CQM);
    assign cq_prod = 64'(r_range[31:1]) * 64'(cq_m);
    assign c_odd   = {r_j, 1'b1};
    assign c_rem   = r_range - 32'(2 * HIST_BINS) * r_cq;
    assign c_var   = (2*MW)'(c_rem[MW-1:0]) * (2*MW)'(c_odd);
    assign cf_prod = CFW'(r_cv) * CFW'(CFM);
    assign c_fine  = MW'(cf_prod >> CFS);
    assign ctr_sum = {1'b0, r_min} + {1'b0, r_cp} + 33'(c_fine);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_CLEAR: if (r_i == GCW'(MAX_GRAINS - 1)) n_state = BS_IDLE;
            BS_IDLE: begin
                if (pop) begin
                    if (cmd.op == OP_FINISH) begin
                        n_state = (n_c == '0) ? BS_RANGE : BS_SRD;
                    end else begin
                        n_state = BS_SHARE;
                    end
                end
            end
            BS_SHARE: if (div_done) n_state = BS_MRD;
            BS_MRD:   n_state = BS_MWAIT;
            BS_MWAIT: begin
                if (g_ok) n_state = BS_AUPD;
                else      n_state = last_member ? BS_IDLE : BS_MRD;
            end
            BS_AUPD:  n_state = last_member ? BS_IDLE : BS_MRD;
            BS_SRD:   n_state = BS_SCMP;
            BS_SCMP:  n_state = last_grain ? BS_RANGE : BS_SRD;
            BS_RANGE: n_state = (r_n == '0) ? BS_CMUL : BS_HRD;
            BS_HRD:   n_state = BS_HMUL;
            BS_HMUL: begin
                if (hit) n_state = BS_HDS;
                else     n_state = last_grain ? BS_CMUL : BS_HRD;
            end
            BS_HDS:   n_state = BS_HDIV;
            BS_HDIV:  if (div_done) n_state = last_grain ? BS_CMUL : BS_HRD;
            BS_CMUL:  n_state = BS_CDS;
            BS_CDS:   n_state = BS_CDIV;
            BS_CDIV:  n_state = (r_j == HBW'(HIST_BINS - 1)) ? BS_IDLE : BS_CMUL;
            default:  n_state = BS_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        area_we    = 1'b0;
        area_waddr = r_g;
        area_wdata = upd_sum[32] ? '1 : upd_sum[31:0];
        area_raddr = r_i[GW-1:0];
        div_start  = 1'b0;
        div_rem    = '0;
        div_bits   = i_bin_area;
        div_steps  = 6'(AREA_W);
        div_den    = 32'(cmd.count);
        hist_inc   = 1'b0;
        hist_sel   = q_idx;
        unique case (r_state)
            BS_CLEAR: begin
                area_we    = 1'b1;
                area_waddr = r_i[GW-1:0];
                area_wdata = '0;
            end
            BS_IDLE:  div_start = pop && (cmd.op == OP_ATOM);
            BS_MWAIT: area_raddr = g32[GW-1:0];
            BS_AUPD:  area_we = 1'b1;
            BS_HMUL: begin
                hist_inc = !hit;
                hist_sel = '0;
            end
            BS_HDS: begin
                div_start = 1'b1;
                div_rem   = r_prod[PW-1:MW];
                div_bits  = {r_prod[MW-1:0], {(AREA_W - MW){1'b0}}};
                div_steps = 6'(MW);
                div_den   = r_range;
            end
            BS_HDIV:  hist_inc = div_done;
            default: ;
        endcase
    end

    assign o_q_pop     = pop;
    assign o_mem_raddr = {r_bank, r_k[MAW-1:0]};
    assign o_stat      = '{clearing: (r_state == BS_CLEAR),
                           active: (r_state != BS_CLEAR) && (r_state != BS_IDLE)};

    // sequencer registers and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_CLEAR;
            r_i     <= '0;
            r_valid <= 1'b0;
            r_min   <= '0;
            r_max   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            case (r_state)
                BS_CLEAR: r_i <= r_i + GCW'(1);
                BS_IDLE: begin
                    if (pop) begin
                        r_bank <= cmd.bank;
                        r_cnt  <= cmd.count;
                        r_k    <= '0;
                        r_n    <= n_c;
                        r_min  <= i_box_area;
                        r_max  <= '0;
                        r_i    <= '0;
                        r_j    <= '0;
                    end
                end
                BS_SHARE: if (div_done) r_share <= div_quot;
                BS_MWAIT: begin
                    if (g_ok) r_g <= g32[GW-1:0];
                    else      r_k <= r_k + CNTW'(1);
                end
                BS_AUPD:  r_k <= r_k + CNTW'(1);
                BS_SCMP: begin
                    if (area_rdata > r_max) r_max <= area_rdata;
                    if (area_rdata < r_min) r_min <= area_rdata;
                    r_i <= r_i + GCW'(1);
                end
                BS_RANGE: begin
                    r_range <= (r_max >= r_min) ? (r_max - r_min) : '0;
                    r_i     <= '0;
                end
                BS_HMUL: begin
                    if (hit) r_prod <= PW'(area_rdata - r_min) * PW'(HIST_BINS);
                    else     r_i <= r_i + GCW'(1);
                end
                BS_HDIV:  if (div_done) r_i <= r_i + GCW'(1);
                BS_CMUL:  r_cq <= 32'(cq_prod >> CQS);
                BS_CDS: begin
                    r_cp <= 32'(c_odd) * r_cq;
                    r_cv <= c_var;
                end
                BS_CDIV: begin
                    r_valid     <= 1'b1;
                    r_bin_index <= r_j;
                    r_centre    <= ctr_sum[32] ? '1 : ctr_sum[31:0];
                    r_total     <= r_hist[r_j];
                    r_last      <= (r_j == HBW'(HIST_BINS - 1));
                    r_j         <= r_j + HBW'(1);
                end
                default: ;
            endcase
        end
    end

    // histogram counters
    always_ff @(posedge i_clk) begin
        if (r_state == BS_RANGE) begin
            for (int b = 0; b < HIST_BINS; b++) begin
                r_hist[b] <= '0;
            end
        end else if (hist_inc && (r_hist[hist_sel] != GT_MAX)) begin
            r_hist[hist_sel] <= r_hist[hist_sel] + GT_W'(1);
        end
    end

    assign o_valid       = r_valid;
    assign o_bin_index   = r_bin_index;
    assign o_bin_centre  = r_centre;
    assign o_grain_total = r_total;
    assign o_last_bin    = r_last;

    // checks
    `GAH_ASSERT_IMPL(a_last_idx, o_valid && o_last_bin, o_bin_index == HBW'(HIST_BINS - 1), "last result not on top bin")
    `GAH_ASSERT_NEXT(a_spaced, o_valid, !o_valid, "results back to back")
    `GAH_ASSERT_IMPL(a_div_free, div_start, !div_busy, "divider started while busy")
    `GAH_ASSERT_IMPL(a_pop_ok, o_q_pop, i_q_count != '0, "pop from empty queue")
endmodule

// ===== rtl/grain_area_histogram.sv =====
// Top level of the grain area histogram block: APB register file, request
// handshake, member RAM, queue. Depends on gah_pkg and all gah_* modules.
//
// Usage:
// - Requests enter on start/busy: a request is taken at a clock edge with start
//   high and busy low. Opcode atom buffers one grain id of the open spatial bin;
//   last_in_bin closes the bin. Opcode finish runs the histogram.
// - A bin close leaves the queue, runs the 32-step share divide, then for each
//   buffered atom does a member read, area read and area write; a grain id
//   beyond the store is skipped after its member read.
// - A finish runs the min/max scan over the grains, then a bin-index divide per
//   grain (skipped for a grain below the minimum or with a zero range), then the
//   centre of each result in the CMUL, CDS and CDIV states.
// - Results appear on o_valid for one cycle each, HIST_BINS of them, the last
//   flagged by o_last_bin; the receiver cannot stall.
// - Up to two requests may wait in the queue; busy rises when the queue and
//   the back end together hold two.
// - After reset the area store is cleared while busy is held high.
// - The user must write registers over APB only while idle; the block does not enforce it.
module grain_area_histogram #(
    parameter int MAX_GRAINS    = gah_pkg::DEF_MAX_GRAINS,
    parameter int MAX_BIN_ATOMS = gah_pkg::DEF_MAX_BIN_ATOMS,
    parameter int HIST_BINS     = gah_pkg::DEF_HIST_BINS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gah_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_opcode,
    input  logic [gah_pkg::GID_W-1:0]     i_grain_id,
    input  logic                          i_last_in_bin,
    output logic                          o_valid,
    output logic [$clog2(HIST_BINS)-1:0]  o_bin_index,
    output logic [gah_pkg::AREA_W-1:0]    o_bin_centre,
    output logic [gah_pkg::GT_W-1:0]      o_grain_total,
    output logic                          o_last_bin
);
    import gah_pkg::*;

    localparam int MAW   = (MAX_BIN_ATOMS > 1) ? $clog2(MAX_BIN_ATOMS) : 1;
    localparam int CNTW  = $clog2(MAX_BIN_ATOMS + 1);
    localparam int CMD_W = CNTW + 2;

    logic [31:0]        r_bin_area;
    logic [GCNT_W-1:0]  r_grain_count;
    logic [31:0]        r_box_area;
    logic               apb_wr;
    t_reg               reg_sel;
    logic               accept;
    logic               mem_we;
    logic [MAW:0]       mem_waddr;
    logic [GID_W-1:0]   mem_wdata;
    logic [MAW:0]       mem_raddr;
    logic [GID_W-1:0]   mem_rdata;
    logic               push;
    logic [CMD_W-1:0]   push_cmd;
    logic               pop;
    logic [CMD_W-1:0]   head_cmd;
    logic [QCW-1:0]     q_count;
    t_back_stat         stat;
    logic [QCW:0]       pending;

    // APB register file
    assign pready  = 1'b1;
    assign apb_wr  = psel && penable && pwrite;
    assign reg_sel = t_reg'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_area    <= 32'h0001_0000;
            r_grain_count <= GCNT_W'(DEF_MAX_GRAINS);
            r_box_area    <= '1;
        end else if (apb_wr) begin
            unique case (reg_sel)
                REG_BIN_AREA:    r_bin_area    <= pwdata;
                REG_GRAIN_COUNT: r_grain_count <= pwdata[GCNT_W-1:0];
                REG_BOX_AREA:    r_box_area    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_BIN_AREA:    prdata = r_bin_area;
            REG_GRAIN_COUNT: prdata = 32'(r_grain_count);
            REG_BOX_AREA:    prdata = r_box_area;
            default:         prdata = '0;
        endcase
    end

    // request handshake: hold off while clearing or two requests outstanding
    assign pending = {1'b0, q_count} + (QCW + 1)'(stat.active);
    assign busy    = stat.clearing || (pending >= (QCW + 1)'(QUEUE_DEPTH));
    assign accept  = start && !busy;

    gah_front #(.MAX_BIN_ATOMS(MAX_BIN_ATOMS), .MAW(MAW), .CNTW(CNTW)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_opcode     (i_opcode),
        .i_grain_id   (i_grain_id),
        .i_last_in_bin(i_last_in_bin),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    gah_ram #(.W(GID_W), .D(2 << MAW)) u_members (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    gah_cmd_queue #(.W(CMD_W)) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_din  (push_cmd),
        .i_pop  (pop),
        .o_dout (head_cmd),
        .o_count(q_count)
    );

    gah_back #(
        .MAX_GRAINS   (MAX_GRAINS),
        .MAX_BIN_ATOMS(MAX_BIN_ATOMS),
        .HIST_BINS    (HIST_BINS),
        .MAW          (MAW),
        .CNTW         (CNTW),
        .HBW          ($clog2(HIST_BINS))
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_bin_area   (r_bin_area),
        .i_grain_count(r_grain_count),
        .i_box_area   (r_box_area),
        .i_q_cmd      (head_cmd),
        .i_q_count    (q_count),
        .o_q_pop      (pop),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata),
        .o_stat       (stat),
        .o_valid      (o_valid),
        .o_bin_index  (o_bin_index),
        .o_bin_centre (o_bin_centre),
        .o_grain_total(o_grain_total),
        .o_last_bin   (o_last_bin)
    );
endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for grain_area_histogram: drives atom and finish
// requests, predicts area accumulation and the 25-bin histogram, checks results.
// Depends on gah_pkg and the grain_area_histogram RTL.
`timescale 1ns / 100ps

module tb_top;
    import gah_pkg::*;

    localparam int NGRAINS   = 1024;
    localparam int NMEMBERS  = 64;
    localparam int NBINS     = 25;
    localparam int SETTLE    = 400;

    // One histogram result
    typedef struct {
        logic [4:0]  index;
        logic [31:0] centre;
        logic [10:0] total;
        logic        last;
    } t_bin_result;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic start, busy;
    logic i_opcode;
    logic [GID_W-1:0] i_grain_id;
    logic i_last_in_bin;
    logic o_valid;
    logic [4:0] o_bin_index;
    logic [31:0] o_bin_centre;
    logic [10:0] o_grain_total;
    logic o_last_bin;

    // Predictor state and settings
    logic [31:0] pred_area [NGRAINS];
    logic [9:0]  bin_ids [NMEMBERS];
    int unsigned bin_fill;
    logic [31:0] cfg_bin_area;
    logic [10:0] cfg_grain_count;
    logic [31:0] cfg_box_area;

    t_bin_result pending_bins [$];
    int unsigned n_errors;
    bit          gaps_on;

    grain_area_histogram i_dut (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
        .pready, .start, .busy, .i_opcode, .i_grain_id, .i_last_in_bin,
        .o_valid, .o_bin_index, .o_bin_centre, .o_grain_total, .o_last_bin
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("grain_area_histogram test failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_errors++;
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    // Area accumulation for one atom request
    task automatic predict_atom(input logic [9:0] gid, input logic last);
        logic [31:0] share;
        logic [32:0] sum;
        if (bin_fill < NMEMBERS) begin
            bin_ids[bin_fill] = gid;
            bin_fill++;
        end
        if (last && bin_fill != 0) begin
            share = cfg_bin_area / bin_fill;
            for (int k = 0; k < bin_fill; k++) begin
                sum = {1'b0, pred_area[bin_ids[k]]} + {1'b0, share};
                pred_area[bin_ids[k]] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end
            bin_fill = 0;
        end
    endtask

    // Min/max scan and histogram for a finish request
    task automatic predict_histogram();
        int unsigned n;
        logic [31:0] lo, hi;
        logic [63:0] span, idx, c;
        logic [10:0] counts [NBINS];
        t_bin_result r;
        n = (cfg_grain_count > NGRAINS) ? NGRAINS : cfg_grain_count;
        lo = cfg_box_area;
        hi = '0;
        for (int i = 0; i < n; i++) begin
            if (pred_area[i] > hi) hi = pred_area[i];
            if (pred_area[i] < lo) lo = pred_area[i];
        end
        span = (hi >= lo) ? 64'(hi - lo) : 64'd0;
        foreach (counts[b]) counts[b] = '0;
        for (int i = 0; i < n; i++) begin
            idx = 0;
            if (span != 0 && pred_area[i] >= lo) begin
                idx = (64'(pred_area[i] - lo) * NBINS) / span;
                if (idx > NBINS - 1) idx = NBINS - 1;
            end
            if (counts[idx] != 11'h7FF) counts[idx]++;
        end
        for (int b = 0; b < NBINS; b++) begin
            c = 64'(lo) + (64'(2 * b + 1) * span) / (2 * NBINS);
            r.index  = 5'(b);
            r.centre = (c > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : c[31:0];
            r.total  = counts[b];
            r.last   = (b == NBINS - 1);
            pending_bins.push_back(r);
        end
        bin_fill = 0;
    endtask

    // Register write, setup then access
    task automatic write_reg(input t_reg idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BIN_AREA:    cfg_bin_area = value;
            REG_GRAIN_COUNT: cfg_grain_count = value[10:0];
            REG_BOX_AREA:    cfg_box_area = value;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [31:0] area, input logic [31:0] count,
                             input logic [31:0] box);
        write_reg(REG_BIN_AREA, area);
        write_reg(REG_GRAIN_COUNT, count);
        write_reg(REG_BOX_AREA, box);
    endtask

    // Send one request; start stays high afterwards unless a gap follows
    task automatic send_request(input t_op op, input logic [9:0] gid, input logic last);
        bit taken;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_opcode      <= op;
        i_grain_id    <= gid;
        i_last_in_bin <= last;
        do begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end while (!taken);
        if (op == OP_FINISH) predict_histogram();
        else predict_atom(gid, last);
    endtask

    // Lets the block go idle before the registers change
    task automatic drain();
        start <= 1'b0;
        while (pending_bins.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Result checking
    always @(negedge i_clk) begin
        t_bin_result want;
        if (i_rst_n && o_valid) begin
            if (pending_bins.size() == 0) begin
                report_mismatch("unexpected result", 32'(o_bin_index), 32'd0);
            end else begin
                want = pending_bins.pop_front();
                if (o_bin_index !== want.index)
                    report_mismatch("bin_index", 32'(o_bin_index), 32'(want.index));
                if (o_bin_centre !== want.centre)
                    report_mismatch("bin_centre", o_bin_centre, want.centre);
                if (o_grain_total !== want.total)
                    report_mismatch("grain_total", 32'(o_grain_total), 32'(want.total));
                if (o_last_bin !== want.last)
                    report_mismatch("last_bin", 32'(o_last_bin), 32'(want.last));
            end
        end
    end

    // Zero range straight after reset, then an empty scan
    task automatic test_reset_state();
        send_request(OP_FINISH, 10'h3FF, 1'b1);
        drain();
        configure(32'h0001_0000, 0, 32'h1234_5678);
        send_request(OP_FINISH, 10'h000, 1'b0);
        drain();
    endtask

    // Field extremes, saturation, open bin at finish
    task automatic test_directed();
        configure(32'hFFFF_FFFF, 4, 32'h0000_0000);
        send_request(OP_ATOM, 10'h3FF, 1'b1);
        send_request(OP_ATOM, 10'h000, 1'b1);
        send_request(OP_ATOM, 10'h000, 1'b1);
        send_request(OP_ATOM, 10'h003, 1'b0);
        send_request(OP_ATOM, 10'h002, 1'b1);
        send_request(OP_FINISH, 10'h155, 1'b0);
        drain();
        configure(32'h0003_0000, 2047, 32'hFFFF_FFFF);
        send_request(OP_ATOM, 10'h001, 1'b0);
        send_request(OP_ATOM, 10'h2AA, 1'b0);
        send_request(OP_FINISH, 10'h000, 1'b1);
        send_request(OP_ATOM, 10'h001, 1'b1);
        send_request(OP_ATOM, 10'h003, 1'b1);
        send_request(OP_FINISH, 10'h3FF, 1'b0);
        drain();
    endtask

    // More atoms in one bin than the buffer holds
    task automatic test_full_bin();
        configure(32'h0064_0000, 16, 32'hFFFF_FFFF);
        for (int i = 0; i < 70; i++)
            send_request(OP_ATOM, 10'($urandom_range(0, 15)), i == 69);
        send_request(OP_FINISH, 10'h0, 1'b0);
        drain();
    endtask

    // Random bins of grains within the count, some noise, finishes
    task automatic test_random_bins();
        logic [31:0] area, box;
        int unsigned count, sent, bin_len;
        for (int phase = 0; phase < 6; phase++) begin
            gaps_on = (phase < 5);
            count = (phase == 2) ? 1 : $urandom_range(2, 48);
            area  = ($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(0, 32'h0010_0000);
            box   = ($urandom_range(0, 2) == 0) ? $urandom() : 32'hFFFF_FFFF;
            configure(area, count, box);
            sent = 0;
            while (sent < 26) begin
                bin_len = $urandom_range(1, 8);
                for (int k = 0; k < bin_len; k++) begin
                    if ($urandom_range(0, 9) == 0)
                        send_request(OP_ATOM, 10'($urandom()), 1'($urandom()));
                    else
                        send_request(OP_ATOM, 10'($urandom_range(0, count - 1)),
                                     k == bin_len - 1);
                    sent++;
                end
                if ($urandom_range(0, 9) == 0) begin
                    send_request(OP_FINISH, 10'($urandom()), 1'($urandom()));
                    sent++;
                end
            end
            send_request(OP_FINISH, 10'($urandom()), 1'($urandom()));
            drain();
        end
    endtask

    initial begin
        n_errors = 0;
        bin_fill = 0;
        gaps_on  = 1'b1;
        foreach (pred_area[g]) pred_area[g] = '0;
        cfg_bin_area    = 32'h0001_0000;
        cfg_grain_count = 11'd1024;
        cfg_box_area    = 32'hFFFF_FFFF;
        i_rst_n <= 1'b0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
        start <= 1'b0; i_opcode <= 1'b0; i_grain_id <= '0; i_last_in_bin <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // area store clears after reset
        repeat (NGRAINS + 100) @(posedge i_clk);

        test_reset_state();
        test_directed();
        test_full_bin();
        test_random_bins();

        drain();
        if (n_errors == 0) begin
            $display("grain_area_histogram test passed");
        end else begin
            $display("grain_area_histogram test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/gah_pkg.sv
rtl/gah_ram.sv
rtl/gah_cmd_queue.sv
rtl/gah_front.sv
rtl/gah_div.sv
rtl/gah_back.sv
rtl/grain_area_histogram.sv
verif/tb_top.sv
